// ===== rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants, types and the crc-16/x-25 byte step for the deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int LIM_MAX     = (STORE_DEPTH < 128) ? STORE_DEPTH : 128;
    localparam int LIM_MIN     = 4;
    localparam int MIN_FRAME   = 4;
    localparam int CRC_LAG     = 3;

    localparam logic [7:0]  HEAD_BYTE = 8'hDA;
    localparam logic [7:0]  CTRL_BYTE = 8'hFA;
    localparam logic [7:0]  TAIL_BYTE = 8'h0A;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    localparam logic [2:0] ST_PAYLOAD    = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_CRC_BAD    = 3'd2;
    localparam logic [2:0] ST_BAD_ESCAPE = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;

    localparam logic REG_FRAME_LIMIT = 1'b0;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic             err;
        logic [2:0]       code;
        logic             good;
        logic [CNT_W-1:0] count;
    } frame_evt_t;

    typedef enum logic [2:0] {
        OUT_IDLE = 3'b001,
        OUT_READ = 3'b010,
        OUT_SEND = 3'b100
    } out_state_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/sfd_frame_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_frame_store
// Frame byte memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sfd_frame_store (
    input  logic                      aclk,
    input  sfd_pkg::mem_wr_t          wr,
    input  logic                      rd_en,
    input  logic [sfd_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                rd_data
);
    import sfd_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sfd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_parser
// Per-byte unstuffing, framing, store writes and running crc check.
// ----------------------------------------------------------------------------
module sfd_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic [7:0]            frame_limit,
    output sfd_pkg::mem_wr_t      wr,
    output sfd_pkg::frame_evt_t   evt
);
    import sfd_pkg::*;

    logic             in_frame_reg, in_frame_next;
    logic             esc_reg, esc_next;
    logic [7:0]       prev_reg, prev_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [15:0]      crc_reg, crc_next;
    // last three stored bytes, index 0 newest
    logic [7:0]       win_reg [3];
    logic [7:0]       win_next [3];

    logic [7:0]       lim8;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] half_lim;
    logic [CNT_W-1:0] body_len;
    logic             is_head;
    logic             is_tail;
    logic             do_store;
    logic             bad_esc;
    logic [7:0]       prev_val;

    always_comb begin
        lim8 = frame_limit;
        if (lim8 < 8'(LIM_MIN)) begin
            lim8 = 8'(LIM_MIN);
        end
        if (lim8 > 8'(LIM_MAX)) begin
            lim8 = 8'(LIM_MAX);
        end
    end

    assign lim      = CNT_W'(lim8);
    assign half_lim = lim >> 1;
    assign body_len = fill_reg - CNT_W'(CRC_LAG);
    assign is_head  = (data_byte == HEAD_BYTE) && (prev_reg == HEAD_BYTE);
    assign is_tail  = (data_byte == TAIL_BYTE) && (prev_reg == TAIL_BYTE);

    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        prev_next     = prev_reg;
        fill_next     = fill_reg;
        crc_next      = crc_reg;
        win_next      = win_reg;
        wr            = '0;
        evt           = '0;
        do_store      = 1'b0;
        bad_esc       = 1'b0;
        prev_val      = data_byte;
        if (accept) begin
            if (is_head) begin
                fill_next     = '0;
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                prev_next     = data_byte;
                crc_next      = CRC_INIT;
            end else if (!in_frame_reg) begin
                prev_next = data_byte;
            end else if (is_tail) begin
                in_frame_next = 1'b0;
                prev_next     = data_byte;
                if (fill_reg < CNT_W'(MIN_FRAME)) begin
                    evt.err  = 1'b1;
                    evt.code = ST_TOO_SHORT;
                end else if (~crc_reg != {win_reg[2], win_reg[1]}) begin
                    evt.err  = 1'b1;
                    evt.code = ST_CRC_BAD;
                end else begin
                    evt.good  = 1'b1;
                    evt.count = (body_len < half_lim) ? body_len : half_lim;
                end
            end else begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                    if (data_byte == HEAD_BYTE || data_byte == TAIL_BYTE
                        || data_byte == CTRL_BYTE) begin
                        do_store = 1'b1;
                        prev_val = CTRL_BYTE;
                    end else begin
                        bad_esc = 1'b1;
                    end
                end else if (data_byte == CTRL_BYTE) begin
                    esc_next = 1'b1;
                end else begin
                    do_store = 1'b1;
                end

                if (bad_esc) begin
                    in_frame_next = 1'b0;
                    prev_next     = data_byte;
                    evt.err       = 1'b1;
                    evt.code      = ST_BAD_ESCAPE;
                end else begin
                    if (do_store && fill_reg < lim) begin
                        wr.en       = 1'b1;
                        wr.addr     = fill_reg[ADDR_W-1:0];
                        wr.data     = data_byte;
                        fill_next   = fill_reg + CNT_W'(1);
                        win_next[0] = data_byte;
                        win_next[1] = win_reg[0];
                        win_next[2] = win_reg[1];
                        if (fill_reg >= CNT_W'(CRC_LAG)) begin
                            crc_next = crc16_byte(crc_reg, win_reg[2]);
                        end
                    end
                    prev_next = prev_val;
                    if (fill_next >= lim) begin
                        in_frame_next = 1'b0;
                        evt.err       = 1'b1;
                        evt.code      = ST_OVERFLOW;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            prev_reg     <= '0;
            fill_reg     <= '0;
            crc_reg      <= CRC_INIT;
        end else begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            prev_reg     <= prev_next;
            fill_reg     <= fill_next;
            crc_reg      <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

// ===== rtl/sfd_out_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_out_ctrl
// Result sequencer: error words, payload readout from the store, error tally.
// ----------------------------------------------------------------------------
module sfd_out_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sfd_pkg::frame_evt_t        evt,
    output logic                       in_ready,
    output logic                       rd_en,
    output logic [sfd_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_payload,
    output logic                       m_last,
    output logic [2:0]                 m_status,
    output logic [15:0]                m_errors
);
    import sfd_pkg::*;

    out_state_t        state_reg, state_next;
    logic              valid_reg, valid_next;
    logic [7:0]        payload_reg, payload_next;
    logic              last_reg, last_next;
    logic [2:0]        status_reg, status_next;
    logic [15:0]       errors_reg, errors_next;
    logic [15:0]       tally_reg, tally_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              out_free;
    logic              is_last;

    assign out_free = !valid_reg || m_ready;
    assign in_ready = (state_reg == OUT_IDLE) && out_free;
    assign is_last  = ({1'b0, idx_reg} == (cnt_reg - CNT_W'(1)));
    assign rd_en    = (state_reg == OUT_READ);
    assign rd_addr  = idx_reg;

    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg && !m_ready;
        payload_next = payload_reg;
        last_next    = last_reg;
        status_next  = status_reg;
        errors_next  = errors_reg;
        tally_next   = tally_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        unique case (state_reg)
            OUT_IDLE: begin
                if (evt.err) begin
                    tally_next   = tally_reg + 16'd1;
                    valid_next   = 1'b1;
                    payload_next = '0;
                    last_next    = 1'b1;
                    status_next  = evt.code;
                    errors_next  = tally_reg + 16'd1;
                end else if (evt.good) begin
                    cnt_next   = evt.count;
                    idx_next   = '0;
                    state_next = OUT_READ;
                end
            end
            OUT_READ: begin
                state_next = OUT_SEND;
            end
            OUT_SEND: begin
                if (out_free) begin
                    valid_next   = 1'b1;
                    payload_next = rd_data;
                    last_next    = is_last;
                    status_next  = ST_PAYLOAD;
                    errors_next  = tally_reg;
                    if (is_last) begin
                        state_next = OUT_IDLE;
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = OUT_READ;
                    end
                end
            end
            default: begin
                state_next = OUT_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= OUT_IDLE;
            valid_reg <= 1'b0;
            tally_reg <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            tally_reg <= tally_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
        last_reg    <= last_next;
        status_reg  <= status_next;
        errors_reg  <= errors_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
    end

    assign m_valid   = valid_reg;
    assign m_payload = payload_reg;
    assign m_last    = last_reg;
    assign m_status  = status_reg;
    assign m_errors  = errors_reg;

`ifndef SYNTHESIS
    a_onehot_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("output sequencer state not one-hot");

    a_err_bumps_tally: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == OUT_IDLE && evt.err) |=>
            (valid_reg && last_reg && errors_reg == tally_reg
             && tally_reg == $past(tally_reg) + 16'd1))
        else $error("error word without tally update");

    a_good_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == OUT_IDLE && evt.good) |=> (state_reg == OUT_READ))
        else $error("good frame did not start readout");

    a_no_evt_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != OUT_IDLE) |-> (!evt.err && !evt.good))
        else $error("frame event while readout busy");

    a_payload_keeps_tally: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == OUT_SEND && out_free) |=>
            (status_reg == ST_PAYLOAD && errors_reg == tally_reg))
        else $error("payload word carries wrong tally");
`endif

endmodule

// ===== rtl/stuffed_frame_deframer_crc16_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_deframer_crc16_unit
// Byte-stuffed frame deframer with crc-16/x-25 check and error tally.
// ----------------------------------------------------------------------------
// A received byte is accepted whenever the output sequencer is idle and the
// output word is free or being taken. Bytes are unstuffed and written into
// the frame store while the crc runs three bytes behind, so the check is
// ready at the closing pair. A good frame's payload, capped at half the
// clamped frame_limit, is then read back from the store with one memory
// read and one output load per payload byte, and no byte is taken during
// that readout. Error events give a single word in the cycle after the byte.
// frame_limit sits at byte address 0 of the register port and resets to 128.
module stuffed_frame_deframer_crc16_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [23:8] errors_seen
    output logic        m_tlast,
    output logic [2:0]  m_tuser    // [2:0] status
);
    import sfd_pkg::*;

    logic [7:0]        frame_limit_reg, frame_limit_next;
    logic              accept;
    mem_wr_t           mem_wr;
    frame_evt_t        evt;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              in_ready;
    logic [7:0]        out_payload;
    logic [15:0]       out_errors;

    assign pready = 1'b1;

    always_comb begin
        frame_limit_next = frame_limit_reg;
        if (psel && penable && pwrite && paddr[2] == REG_FRAME_LIMIT) begin
            frame_limit_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_limit_reg <= 8'd128;
        end else begin
            frame_limit_reg <= frame_limit_next;
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_LIMIT) ? {24'd0, frame_limit_reg} : 32'd0;

    assign s_tready = in_ready;
    assign accept   = s_tvalid && in_ready;

    sfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_tdata),
        .frame_limit (frame_limit_reg),
        .wr          (mem_wr),
        .evt         (evt)
    );

    sfd_frame_store u_store (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfd_out_ctrl u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt       (evt),
        .in_ready  (in_ready),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_payload (out_payload),
        .m_last    (m_tlast),
        .m_status  (m_tuser),
        .m_errors  (out_errors)
    );

    assign m_tdata = {out_errors, out_payload};

endmodule
